[rtl/core/mfrd_pkg.sv]
// ----------------------------------------------------------------------------
// mfrd_pkg
// Shared types and constants for the MAC frame receive deframer.
// ----------------------------------------------------------------------------
package mfrd_pkg;

  // Header is 9 bytes with short addressing and a compressed PAN ID.
  localparam logic [6:0] HDR_SHORT  = 7'd9;
  localparam logic [6:0] SPAN_BYTES = 7'd2;
  localparam logic [6:0] TAIL_BYTES = 7'd4;
  localparam logic [1:0] FCS_BYTES  = 2'd2;
  localparam logic [6:0] LEN_MIN    = HDR_SHORT + TAIL_BYTES;
  localparam logic [6:0] LEN_MIN_SPAN = HDR_SHORT + SPAN_BYTES + TAIL_BYTES;

  // Frame control bit for PAN ID compression.
  localparam int unsigned FC_PANID_COMP = 6;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_END    = 2'd2,
    KIND_LEN_ERR = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_FC_LO    = 4'd1,
    PH_FC_HI    = 4'd2,
    PH_SEQ      = 4'd3,
    PH_DPAN_LO  = 4'd4,
    PH_DPAN_HI  = 4'd5,
    PH_DADDR_LO = 4'd6,
    PH_DADDR_HI = 4'd7,
    PH_SPAN_LO  = 4'd8,
    PH_SPAN_HI  = 4'd9,
    PH_SADDR_LO = 4'd10,
    PH_SADDR_HI = 4'd11,
    PH_STATUS   = 4'd12,
    PH_TYPE     = 4'd13,
    PH_DATA     = 4'd14,
    PH_TRAIL    = 4'd15
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] frame_control;
    logic [7:0]  sequence_number;
    logic [15:0] dest_pan;
    logic [15:0] dest_short_addr;
    logic [15:0] source_pan;
    logic [15:0] source_address;
    logic [7:0]  status_byte;
    logic [7:0]  type_byte;
    logic [7:0]  data_byte;
    logic [7:0]  link_quality;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       accept;
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       crc_ok;
  } byte_in_t;

endpackage

[rtl/core/mfrd_parser.sv]
// ----------------------------------------------------------------------------
// mfrd_parser
// Frame phase tracking, header field capture and result formation per byte.
// ----------------------------------------------------------------------------
module mfrd_parser
  import mfrd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 127
) (
  input  logic     clk,
  input  logic     rst_n,
  input  byte_in_t byte_in,
  output logic     res_valid,
  output result_t  res
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  byte_count_r, byte_count_nxt;
  logic [6:0]  payload_left_r, payload_left_nxt;
  logic [6:0]  frame_length_r, frame_length_nxt;
  logic [15:0] fc_r, fc_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] dpan_r, dpan_nxt;
  logic [15:0] daddr_r, daddr_nxt;
  logic [15:0] span_r, span_nxt;
  logic [15:0] saddr_r, saddr_nxt;
  logic [7:0]  status_r, status_nxt;

  logic [7:0] b;
  logic [6:0] need;

  assign b    = byte_in.rx_byte;
  // compression bit sits in the low frame control byte, already captured
  assign need = fc_r[FC_PANID_COMP] ? LEN_MIN : LEN_MIN_SPAN;

  always_comb begin
    phase_nxt        = phase_r;
    byte_count_nxt   = byte_count_r;
    payload_left_nxt = payload_left_r;
    frame_length_nxt = frame_length_r;
    fc_nxt           = fc_r;
    seq_nxt          = seq_r;
    dpan_nxt         = dpan_r;
    daddr_nxt        = daddr_r;
    span_nxt         = span_r;
    saddr_nxt        = saddr_r;
    status_nxt       = status_r;
    res_valid        = 1'b0;
    res              = '0;

    if (byte_in.accept) begin
      if (byte_in.frame_start) begin
        phase_nxt = PH_IDLE;
        if (byte_in.crc_ok) begin
          if (b > 8'(MAX_FRAME_BYTES) || b < {1'b0, LEN_MIN}) begin
            res_valid = 1'b1;
            res.kind  = KIND_LEN_ERR;
          end else begin
            frame_length_nxt = b[6:0];
            byte_count_nxt   = '0;
            payload_left_nxt = '0;
            phase_nxt        = PH_FC_LO;
          end
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: ;
          PH_FC_LO: begin
            fc_nxt    = {fc_r[15:8], b};
            phase_nxt = PH_FC_HI;
          end
          PH_FC_HI: begin
            fc_nxt = {b, fc_r[7:0]};
            if (frame_length_r < need) begin
              phase_nxt = PH_IDLE;
              res_valid = 1'b1;
              res.kind  = KIND_LEN_ERR;
            end else begin
              payload_left_nxt = frame_length_r - need;
              phase_nxt        = PH_SEQ;
            end
          end
          PH_SEQ: begin
            seq_nxt   = b;
            phase_nxt = PH_DPAN_LO;
          end
          PH_DPAN_LO: begin
            dpan_nxt  = {dpan_r[15:8], b};
            phase_nxt = PH_DPAN_HI;
          end
          PH_DPAN_HI: begin
            dpan_nxt  = {b, dpan_r[7:0]};
            phase_nxt = PH_DADDR_LO;
          end
          PH_DADDR_LO: begin
            daddr_nxt = {daddr_r[15:8], b};
            phase_nxt = PH_DADDR_HI;
          end
          PH_DADDR_HI: begin
            daddr_nxt = {b, daddr_r[7:0]};
            phase_nxt = fc_r[FC_PANID_COMP] ? PH_SADDR_LO : PH_SPAN_LO;
          end
          PH_SPAN_LO: begin
            span_nxt  = {span_r[15:8], b};
            phase_nxt = PH_SPAN_HI;
          end
          PH_SPAN_HI: begin
            span_nxt  = {b, span_r[7:0]};
            phase_nxt = PH_SADDR_LO;
          end
          PH_SADDR_LO: begin
            saddr_nxt = {saddr_r[15:8], b};
            phase_nxt = PH_SADDR_HI;
          end
          PH_SADDR_HI: begin
            saddr_nxt = {b, saddr_r[7:0]};
            phase_nxt = PH_STATUS;
          end
          PH_STATUS: begin
            status_nxt = b;
            phase_nxt  = PH_TYPE;
          end
          PH_TYPE: begin
            res_valid           = 1'b1;
            res.kind            = KIND_HEADER;
            res.frame_control   = fc_r;
            res.sequence_number = seq_r;
            res.dest_pan        = dpan_r;
            res.dest_short_addr = daddr_r;
            res.source_pan      = span_r;
            res.source_address  = saddr_r;
            res.status_byte     = status_r;
            res.type_byte       = b;
            byte_count_nxt      = '0;
            phase_nxt           = (payload_left_r != '0) ? PH_DATA : PH_TRAIL;
          end
          PH_DATA: begin
            res_valid     = 1'b1;
            res.kind      = KIND_DATA;
            res.data_byte = b;
            res.last      = (payload_left_r <= 7'd1);
            if (payload_left_r != '0) begin
              payload_left_nxt = payload_left_r - 7'd1;
            end
            // drop into the trailer once the payload runs out
            if (payload_left_r <= 7'd1) begin
              phase_nxt      = PH_TRAIL;
              byte_count_nxt = '0;
            end
          end
          PH_TRAIL: begin
            if (byte_count_r < FCS_BYTES) begin
              byte_count_nxt = byte_count_r + 2'd1;
            end else begin
              res_valid        = 1'b1;
              res.kind         = KIND_END;
              res.link_quality = b;
              phase_nxt        = PH_IDLE;
              byte_count_nxt   = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      byte_count_r   <= '0;
      payload_left_r <= '0;
      frame_length_r <= '0;
      fc_r           <= '0;
      seq_r          <= '0;
      dpan_r         <= '0;
      daddr_r        <= '0;
      span_r         <= '0;
      saddr_r        <= '0;
      status_r       <= '0;
    end else begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      payload_left_r <= payload_left_nxt;
      frame_length_r <= frame_length_nxt;
      fc_r           <= fc_nxt;
      seq_r          <= seq_nxt;
      dpan_r         <= dpan_nxt;
      daddr_r        <= daddr_nxt;
      span_r         <= span_nxt;
      saddr_r        <= saddr_nxt;
      status_r       <= status_nxt;
    end
  end

  a_bad_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    byte_in.accept && byte_in.frame_start && !byte_in.crc_ok |=> phase_r == PH_IDLE)
    else $error("bad CRC frame not skipped");

  a_trail_count: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= FCS_BYTES)
    else $error("FCS count ran past the checksum bytes");

  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> payload_left_r != '0)
    else $error("payload phase with nothing left");

endmodule

[rtl/core/mac_frame_rx_deframer_top.sv]
// ----------------------------------------------------------------------------
// mac_frame_rx_deframer_top
// Receive deframer for 802.15.4 MAC frames with short addressing.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | rx_byte, frame_start, crc_ok
//  out_    | output    | out_valid/out_stall| kind, header fields, data, lqi
//
//  One word is accepted per cycle while in_stall is low; its result, if any, appears the next cycle.
//  The parser phase, counter and header capture registers and out_valid_r are the loops.
//  Synchronous reset returns the parser to idle and clears all captures.
//  A held result stalls the input only while out_stall is high.
// ----------------------------------------------------------------------------
module mac_frame_rx_deframer_top
  import mfrd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_start,
  input  logic        in_crc_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_frame_control,
  output logic [7:0]  out_sequence_number,
  output logic [15:0] out_dest_pan,
  output logic [15:0] out_dest_short_addr,
  output logic [15:0] out_source_pan,
  output logic [15:0] out_source_address,
  output logic [7:0]  out_status_byte,
  output logic [7:0]  out_type_byte,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_link_quality,
  output logic        out_last
);

  byte_in_t byte_in;
  logic     res_valid;
  result_t  res;
  logic     out_valid_r, out_valid_nxt;
  result_t  out_r;

  assign in_stall = out_valid_r & out_stall;

  assign byte_in.accept      = in_valid & ~in_stall;
  assign byte_in.rx_byte     = in_rx_byte;
  assign byte_in.frame_start = in_frame_start;
  assign byte_in.crc_ok      = in_crc_ok;

  mfrd_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_in  (byte_in),
    .res_valid(res_valid),
    .res      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (byte_in.accept) begin
      out_valid_nxt = res_valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.accept && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_r.kind;
  assign out_frame_control   = out_r.frame_control;
  assign out_sequence_number = out_r.sequence_number;
  assign out_dest_pan        = out_r.dest_pan;
  assign out_dest_short_addr = out_r.dest_short_addr;
  assign out_source_pan      = out_r.source_pan;
  assign out_source_address  = out_r.source_address;
  assign out_status_byte     = out_r.status_byte;
  assign out_type_byte       = out_r.type_byte;
  assign out_data_byte       = out_r.data_byte;
  assign out_link_quality    = out_r.link_quality;
  assign out_last            = out_r.last;

  a_last_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind == KIND_DATA)
    else $error("last flag on non-data result");

  a_header_only_kind0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_HEADER |-> out_frame_control == '0 && out_type_byte == '0)
    else $error("header fields set on non-header result");

  a_result_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(byte_in.accept))
    else $error("result appeared without an accepted word");

endmodule
